/* rtl/gaussian_vertex_deform_defines.svh */
// Assertion macros used by the gaussian vertex deform checker file.
`ifndef GAUSSIAN_VERTEX_DEFORM_DEFINES_SVH
`define GAUSSIAN_VERTEX_DEFORM_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define GVD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds while reset is high.
`define GVD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/gvd_pkg.sv */
// Package with the types, widths and constants of the gaussian vertex deform block.
package gvd_pkg;

   // Table depth of the exponential ROM.
   localparam int EXP_TABLE_DEPTH = 1024;
   localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
   localparam int CNT_W = $clog2(EXP_TABLE_DEPTH + 1);

   // Field widths.
   localparam int CRD_W = 32;             // Q15.16 coordinate
   localparam int NRM_W = 16;             // Q1.14 normal component
   localparam int SIG_W = 16;             // Q8.8 sigma, unsigned
   localparam int WGT_W = 17;             // Q0.16 weight, 1.0 included

   // Cross product datapath.
   localparam int DLT_W = CRD_W + 1;      // pick minus vertex
   localparam int PRD_W = NRM_W + DLT_W;  // normal times delta, Q.30
   localparam int DIF_W = PRD_W + 1;      // cross product component
   localparam int CRS_SHIFT = 14;         // Q.30 to Q.16
   localparam int RND_W = 27;             // saturated magnitude, up to 1024.0
   localparam int SQ_W = 2 * RND_W;
   localparam int D2_W = SQ_W + 2;

   // Division of d^2 by 2 sigma^2, one quotient bit per stage.
   localparam int DEN_W = 2 * SIG_W;
   localparam int XQ_W = 20;              // quotient below 16.0 in Q.16
   localparam int REM_W = DEN_W + XQ_W - 1;

   // Displacement datapath.
   localparam int NP_W = NRM_W + CRD_W;
   localparam int DSP_W = NP_W + WGT_W + 1;
   localparam int DSP_SHIFT = 30;         // Q.46 to Q.16
   localparam int RDS_W = DSP_W - DSP_SHIFT;
   localparam int SUM_W = RDS_W + 2;

   // Pipeline stage positions.
   localparam int ST_DIV = 7;
   localparam int NSTG = ST_DIV + XQ_W + 7;

   // Configuration port.
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 32;

   // Register constants.
   localparam logic [SIG_W-1:0] SIGMA_MIN = 16'd2560;
   localparam logic [SIG_W-1:0] SIGMA_MAX = 16'd32768;
   localparam logic [SIG_W-1:0] SIGMA_RESET = 16'd7680;
   localparam logic signed [NRM_W-1:0] NORMAL_Z_RESET = 16'sd16384;
   localparam logic [RND_W-1:0] CRS_SAT = RND_W'(1) << 26;
   localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << 16;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(EXP_TABLE_DEPTH);
   localparam logic signed [CRD_W-1:0] CRD_MAX = {1'b0, {(CRD_W-1){1'b1}}};
   localparam logic signed [CRD_W-1:0] CRD_MIN = {1'b1, {(CRD_W-1){1'b0}}};

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NORMAL_X,
      CSR_NORMAL_Y,
      CSR_NORMAL_Z,
      CSR_PICK_X,
      CSR_PICK_Y,
      CSR_PICK_Z,
      CSR_PUSH_DISTANCE,
      CSR_FALLOFF_SIGMA
   } csr_reg_type;

   // Request payload: one vertex.
   typedef struct packed {
      logic signed [CRD_W-1:0] vertex_x;
      logic signed [CRD_W-1:0] vertex_y;
      logic signed [CRD_W-1:0] vertex_z;
   } req_data_type;

   // Response payload: moved vertex and its weight.
   typedef struct packed {
      logic signed [CRD_W-1:0] moved_x;
      logic signed [CRD_W-1:0] moved_y;
      logic signed [CRD_W-1:0] moved_z;
      logic [WGT_W-1:0]        falloff_weight;
   } rsp_data_type;

   // Taylor series terms of exp(-16 / depth) in Q.58; term k is term k-1 times 16/(depth k).
   localparam logic [63:0] TAY_DEN = 64'(EXP_TABLE_DEPTH);
   localparam logic [63:0] TAY_0 = 64'd1 << 58;
   localparam logic [63:0] TAY_1 = (TAY_0 * 64'd16) / (TAY_DEN * 64'd1);
   localparam logic [63:0] TAY_2 = (TAY_1 * 64'd16) / (TAY_DEN * 64'd2);
   localparam logic [63:0] TAY_3 = (TAY_2 * 64'd16) / (TAY_DEN * 64'd3);
   localparam logic [63:0] TAY_4 = (TAY_3 * 64'd16) / (TAY_DEN * 64'd4);
   localparam logic [63:0] TAY_5 = (TAY_4 * 64'd16) / (TAY_DEN * 64'd5);
   localparam logic [63:0] TAY_6 = (TAY_5 * 64'd16) / (TAY_DEN * 64'd6);
   localparam logic [63:0] TAY_7 = (TAY_6 * 64'd16) / (TAY_DEN * 64'd7);
   localparam logic [63:0] TAY_8 = (TAY_7 * 64'd16) / (TAY_DEN * 64'd8);
   localparam logic [63:0] TAY_9 = (TAY_8 * 64'd16) / (TAY_DEN * 64'd9);
   localparam logic [63:0] TAY_10 = (TAY_9 * 64'd16) / (TAY_DEN * 64'd10);
   localparam logic [63:0] TAY_11 = (TAY_10 * 64'd16) / (TAY_DEN * 64'd11);
   localparam logic [63:0] TAY_12 = (TAY_11 * 64'd16) / (TAY_DEN * 64'd12);
   localparam logic [63:0] TAY_13 = (TAY_12 * 64'd16) / (TAY_DEN * 64'd13);
   localparam logic [63:0] TAY_14 = (TAY_13 * 64'd16) / (TAY_DEN * 64'd14);
   localparam logic [63:0] TAY_15 = (TAY_14 * 64'd16) / (TAY_DEN * 64'd15);
   localparam logic [63:0] TAY_16 = (TAY_15 * 64'd16) / (TAY_DEN * 64'd16);
   localparam logic [63:0] TAY_17 = (TAY_16 * 64'd16) / (TAY_DEN * 64'd17);
   localparam logic [63:0] TAY_18 = (TAY_17 * 64'd16) / (TAY_DEN * 64'd18);
   localparam logic [63:0] TAY_19 = (TAY_18 * 64'd16) / (TAY_DEN * 64'd19);
   localparam logic [63:0] TAY_20 = (TAY_19 * 64'd16) / (TAY_DEN * 64'd20);
   localparam logic [63:0] TAY_21 = (TAY_20 * 64'd16) / (TAY_DEN * 64'd21);
   localparam logic [63:0] TAY_22 = (TAY_21 * 64'd16) / (TAY_DEN * 64'd22);
   localparam logic [63:0] TAY_23 = (TAY_22 * 64'd16) / (TAY_DEN * 64'd23);
   localparam logic [63:0] TAY_24 = (TAY_23 * 64'd16) / (TAY_DEN * 64'd24);

   // Alternating sum of the terms, then the step factor rounded to Q.32.
   localparam logic [63:0] TAY_SUM = TAY_0 - TAY_1 + TAY_2 - TAY_3 + TAY_4 - TAY_5
                                   + TAY_6 - TAY_7 + TAY_8 - TAY_9 + TAY_10 - TAY_11
                                   + TAY_12 - TAY_13 + TAY_14 - TAY_15 + TAY_16
                                   - TAY_17 + TAY_18 - TAY_19 + TAY_20 - TAY_21
                                   + TAY_22 - TAY_23 + TAY_24;
   localparam logic [63:0] EXP_STEP_RND = (TAY_SUM + (64'd1 << 25)) >> 26;
   localparam logic [31:0] EXP_STEP = (EXP_STEP_RND > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                    : EXP_STEP_RND[31:0];

endpackage

/* rtl/gaussian_vertex_deform.sv */
// Top level of the gaussian vertex deform block: a deep pipeline from vertex to moved vertex.
// The block takes one vertex per request transaction and returns it moved along the
// configured normal by push_distance scaled with a gaussian falloff weight, plus that
// weight. It accepts one vertex every clock cycle while the skid stage is empty and the
// ROM is filled. The datapath is fully pipelined, and the divider forms one quotient
// bit per stage. A two-entry output register and skid stage keep the pipeline running
// while a response waits in the output register; the whole pipeline stalls while the
// skid stage is full. After reset the exponential ROM is filled one entry per cycle, and
// req_ready stays low until all EXP_TABLE_DEPTH (1024) entries are written; CSR writes are
// taken at any time but must only be issued while no transaction is in flight.
module gaussian_vertex_deform (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  gvd_pkg::req_data_type                req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output gvd_pkg::rsp_data_type                rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gvd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gvd_pkg::CSR_DAT_W-1:0]        csr_data
);
   import gvd_pkg::*;

   // Configuration registers.
   logic signed [NRM_W-1:0] nrm_ff [3];
   logic signed [CRD_W-1:0] pick_ff [3];
   logic signed [CRD_W-1:0] push_ff;
   logic [SIG_W-1:0]        sigma_ff;
   logic [SIG_W-1:0]        sigma_raw;
   logic [SIG_W-1:0]        sigma_in;

   // Values derived from the configuration.
   logic [2*SIG_W-1:0]      sig_sq;
   logic [DEN_W-1:0]        denom_in;
   logic [DEN_W-1:0]        denom_ff;
   logic signed [NP_W-1:0]  np_in [3];
   logic signed [NP_W-1:0]  np_ff [3];

   // ROM fill sweep.
   logic [CNT_W-1:0]        fill_cnt_ff;
   logic                    fill_done;
   logic [31:0]             e_ff;
   logic [63:0]             e_prod;
   logic [31:0]             e_in;
   logic [32:0]             e_rnd;
   logic [WGT_W-1:0]        fill_word;
   logic [WGT_W-1:0]        rom_mem [EXP_TABLE_DEPTH];

   // Pipeline control.
   logic                    adv;
   logic                    accept;
   logic                    vld_ff [NSTG];
   req_data_type            vtx_ff [NSTG];

   // Cross product and distance stages.
   logic signed [DLT_W-1:0] dlt_in [3];
   logic signed [DLT_W-1:0] dlt_ff [3];
   logic signed [PRD_W-1:0] prd_in [6];
   logic signed [PRD_W-1:0] prd_ff [6];
   logic signed [DIF_W-1:0] dif_in [3];
   logic signed [DIF_W-1:0] dif_ff [3];
   logic [DIF_W-1:0]        mag_in [3];
   logic [DIF_W-1:0]        mag_ff [3];
   logic [DIF_W:0]          rsum [3];
   logic [DIF_W:0]          rsh [3];
   logic [RND_W-1:0]        rnd_in [3];
   logic [RND_W-1:0]        rnd_ff [3];
   logic [SQ_W-1:0]         sq_in [3];
   logic [SQ_W-1:0]         sq_ff [3];
   logic [D2_W-1:0]         d2_in;
   logic [D2_W-1:0]         d2_ff;

   // Divider stages.
   logic [REM_W-1:0]        rem_in [XQ_W+1];
   logic [REM_W-1:0]        rem_ff [XQ_W+1];
   logic [XQ_W-1:0]         q_in [XQ_W+1];
   logic [XQ_W-1:0]         q_ff [XQ_W+1];
   logic                    far_in [XQ_W+1];
   logic                    far_ff [XQ_W+1];
   logic [REM_W-1:0]        dsh [XQ_W];
   logic                    qbit [XQ_W];

   // Table lookup stages.
   logic [XQ_W+CNT_W-1:0]   idx_prod;
   logic [IDX_W-1:0]        idx_in;
   logic [IDX_W-1:0]        idx_ff;
   logic                    far_idx_ff;
   logic [WGT_W-1:0]        rd_ff;
   logic                    far_rd_ff;
   logic [WGT_W-1:0]        wgt_in;
   logic [WGT_W-1:0]        wgt_ff [4];

   // Displacement stages.
   logic signed [DSP_W-1:0] dsp_in [3];
   logic signed [DSP_W-1:0] dsp_ff [3];
   logic [DSP_W-1:0]        dmag_in [3];
   logic [DSP_W-1:0]        dmag_ff [3];
   logic                    dneg_ff [3];
   logic                    dneg2_ff [3];
   logic [DSP_W-1:0]        dsum [3];
   logic [RDS_W-1:0]        rds_in [3];
   logic [RDS_W-1:0]        rds_ff [3];
   logic signed [CRD_W-1:0] vcrd [3];
   logic signed [SUM_W-1:0] vsum [3];
   logic signed [SUM_W-1:0] rds_s [3];
   logic                    ovf [3];
   logic signed [CRD_W-1:0] mov [3];

   // Output register and skid stage.
   rsp_data_type            pipe_out;
   logic                    pipe_vld;
   logic                    out_free;
   logic                    rsp_valid_in;
   logic                    rsp_valid_ff;
   rsp_data_type            rsp_data_in;
   rsp_data_type            rsp_data_ff;
   logic                    skid_valid_in;
   logic                    skid_valid_ff;
   rsp_data_type            skid_data_in;
   rsp_data_type            skid_data_ff;

   // CSR writes; sigma saturates on the way in.
   assign csr_ready = 1'b1;
   assign sigma_raw = csr_data[SIG_W-1:0];

   always_comb begin
      priority if (sigma_raw < SIGMA_MIN) begin
         sigma_in = SIGMA_MIN;
      end else if (sigma_raw > SIGMA_MAX) begin
         sigma_in = SIGMA_MAX;
      end else begin
         sigma_in = sigma_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nrm_ff[0] <= '0;
         nrm_ff[1] <= '0;
         nrm_ff[2] <= NORMAL_Z_RESET;
         pick_ff[0] <= '0;
         pick_ff[1] <= '0;
         pick_ff[2] <= '0;
         push_ff <= '0;
         sigma_ff <= SIGMA_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NORMAL_X:      nrm_ff[0] <= csr_data[NRM_W-1:0];
            CSR_NORMAL_Y:      nrm_ff[1] <= csr_data[NRM_W-1:0];
            CSR_NORMAL_Z:      nrm_ff[2] <= csr_data[NRM_W-1:0];
            CSR_PICK_X:        pick_ff[0] <= csr_data[CRD_W-1:0];
            CSR_PICK_Y:        pick_ff[1] <= csr_data[CRD_W-1:0];
            CSR_PICK_Z:        pick_ff[2] <= csr_data[CRD_W-1:0];
            CSR_PUSH_DISTANCE: push_ff <= csr_data[CRD_W-1:0];
            CSR_FALLOFF_SIGMA: sigma_ff <= sigma_in;
            default: ;
         endcase
      end
   end

   // Terms that depend on the configuration only: 2 sigma^2 and normal times push.
   always_comb begin
      sig_sq = sigma_ff * sigma_ff;
      denom_in = {sig_sq[DEN_W-2:0], 1'b0};
      for (int j = 0; j < 3; j++) begin
         np_in[j] = NP_W'(nrm_ff[j]) * NP_W'(push_ff);
      end
   end

   always_ff @(posedge clock) begin
      denom_ff <= denom_in;
      np_ff <= np_in;
   end

   // ROM fill: entry i holds exp(-16 i / depth), built by repeated Q.32 products.
   always_comb begin
      e_prod = 64'(e_ff) * 64'(EXP_STEP) + (64'd1 << 31);
      e_in = e_prod[63:32];
      e_rnd = (33'(e_ff) + 33'd32768) >> 16;
      fill_word = (fill_cnt_ff == '0) ? WGT_ONE : e_rnd[WGT_W-1:0];
      fill_done = (fill_cnt_ff == DEPTH_C);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_cnt_ff <= '0;
         e_ff <= EXP_STEP;
      end else if (!fill_done) begin
         fill_cnt_ff <= fill_cnt_ff + CNT_W'(1);
         if (fill_cnt_ff != '0) begin
            e_ff <= e_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!fill_done) begin
         rom_mem[fill_cnt_ff[IDX_W-1:0]] <= fill_word;
      end
   end

   // The whole pipeline moves whenever the skid stage is empty.
   assign adv = !skid_valid_ff;
   assign req_ready = adv && fill_done;
   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTG; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= accept;
         for (int k = 1; k < NSTG; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vtx_ff[0] <= req_data;
         for (int k = 1; k < NSTG; k++) begin
            vtx_ff[k] <= vtx_ff[k-1];
         end
      end
   end

   // Cross product of the normal with pick minus vertex, rounded to Q.16, saturated, squared and summed.
   always_comb begin
      dlt_in[0] = DLT_W'(pick_ff[0]) - DLT_W'(req_data.vertex_x);
      dlt_in[1] = DLT_W'(pick_ff[1]) - DLT_W'(req_data.vertex_y);
      dlt_in[2] = DLT_W'(pick_ff[2]) - DLT_W'(req_data.vertex_z);
      prd_in[0] = PRD_W'(nrm_ff[1]) * PRD_W'(dlt_ff[2]);
      prd_in[1] = PRD_W'(nrm_ff[2]) * PRD_W'(dlt_ff[1]);
      prd_in[2] = PRD_W'(nrm_ff[2]) * PRD_W'(dlt_ff[0]);
      prd_in[3] = PRD_W'(nrm_ff[0]) * PRD_W'(dlt_ff[2]);
      prd_in[4] = PRD_W'(nrm_ff[0]) * PRD_W'(dlt_ff[1]);
      prd_in[5] = PRD_W'(nrm_ff[1]) * PRD_W'(dlt_ff[0]);
      for (int i = 0; i < 3; i++) begin
         dif_in[i] = DIF_W'(prd_ff[2*i]) - DIF_W'(prd_ff[2*i+1]);
         mag_in[i] = dif_ff[i][DIF_W-1] ? $unsigned(-dif_ff[i]) : $unsigned(dif_ff[i]);
         rsum[i] = (DIF_W+1)'(mag_ff[i]) + ((DIF_W+1)'(1) << (CRS_SHIFT - 1));
         rsh[i] = rsum[i] >> CRS_SHIFT;
         rnd_in[i] = (rsh[i] > (DIF_W+1)'(CRS_SAT)) ? CRS_SAT : rsh[i][RND_W-1:0];
         sq_in[i] = SQ_W'(rnd_ff[i]) * SQ_W'(rnd_ff[i]);
      end
      d2_in = D2_W'(sq_ff[0]) + D2_W'(sq_ff[1]) + D2_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dlt_ff <= dlt_in;
         prd_ff <= prd_in;
         dif_ff <= dif_in;
         mag_ff <= mag_in;
         rnd_ff <= rnd_in;
         sq_ff <= sq_in;
         d2_ff <= d2_in;
      end
   end

   // Restoring divider: a quotient of 16.0 or more means zero weight, else one bit a stage.
   always_comb begin
      far_in[0] = d2_ff >= D2_W'({denom_ff, XQ_W'(0)});
      rem_in[0] = d2_ff[REM_W-1:0];
      q_in[0] = '0;
      for (int s = 0; s < XQ_W; s++) begin
         dsh[s] = REM_W'(denom_ff) << (XQ_W - 1 - s);
         qbit[s] = rem_ff[s] >= dsh[s];
         rem_in[s+1] = qbit[s] ? (rem_ff[s] - dsh[s]) : rem_ff[s];
         q_in[s+1] = {q_ff[s][XQ_W-2:0], qbit[s]};
         far_in[s+1] = far_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         q_ff <= q_in;
         far_ff <= far_in;
      end
   end

   // Table index, ROM read with registered data, then the weight.
   always_comb begin
      idx_prod = (XQ_W+CNT_W)'(q_ff[XQ_W]) * (XQ_W+CNT_W)'(DEPTH_C);
      idx_in = idx_prod[XQ_W +: IDX_W];
      wgt_in = far_rd_ff ? '0 : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff <= idx_in;
         far_idx_ff <= far_ff[XQ_W];
         rd_ff <= rom_mem[idx_ff];
         far_rd_ff <= far_idx_ff;
         wgt_ff[0] <= wgt_in;
         wgt_ff[1] <= wgt_ff[0];
         wgt_ff[2] <= wgt_ff[1];
         wgt_ff[3] <= wgt_ff[2];
      end
   end

   // Displacement normal * push * weight, rounded half away from zero to Q.16.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dsp_in[j] = DSP_W'(np_ff[j]) * DSP_W'($signed({1'b0, wgt_ff[0]}));
         dmag_in[j] = dsp_ff[j][DSP_W-1] ? $unsigned(-dsp_ff[j]) : $unsigned(dsp_ff[j]);
         dsum[j] = dmag_ff[j] + (DSP_W'(1) << (DSP_SHIFT - 1));
         rds_in[j] = dsum[j][DSP_SHIFT +: RDS_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dsp_ff <= dsp_in;
         dmag_ff <= dmag_in;
         rds_ff <= rds_in;
         for (int j = 0; j < 3; j++) begin
            dneg_ff[j] <= dsp_ff[j][DSP_W-1];
            dneg2_ff[j] <= dneg_ff[j];
         end
      end
   end

   // Add to the vertex and saturate to the coordinate range.
   always_comb begin
      vcrd[0] = vtx_ff[NSTG-1].vertex_x;
      vcrd[1] = vtx_ff[NSTG-1].vertex_y;
      vcrd[2] = vtx_ff[NSTG-1].vertex_z;
      for (int j = 0; j < 3; j++) begin
         rds_s[j] = SUM_W'($signed({1'b0, rds_ff[j]}));
         vsum[j] = dneg2_ff[j] ? (SUM_W'(vcrd[j]) - rds_s[j]) : (SUM_W'(vcrd[j]) + rds_s[j]);
         ovf[j] = vsum[j][SUM_W-1:CRD_W-1] != {(SUM_W-CRD_W+1){vsum[j][SUM_W-1]}};
         if (ovf[j]) begin
            mov[j] = vsum[j][SUM_W-1] ? CRD_MIN : CRD_MAX;
         end else begin
            mov[j] = vsum[j][CRD_W-1:0];
         end
      end
      pipe_out.moved_x = mov[0];
      pipe_out.moved_y = mov[1];
      pipe_out.moved_z = mov[2];
      pipe_out.falloff_weight = wgt_ff[3];
      pipe_vld = vld_ff[NSTG-1];
   end

   // Output register with a skid stage behind it.
   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (pipe_vld) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in = pipe_out;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in = pipe_out;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

/* rtl/gvd_checker.sv */
// Port checker for the gaussian vertex deform block and its bind statement.
`include "gaussian_vertex_deform_defines.svh"

module gvd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input gvd_pkg::rsp_data_type rsp_data
);
   import gvd_pkg::*;

   // A stalled response keeps its transaction unchanged.
   `GVD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled response changed")

   // The weight never exceeds 1.0.
   `GVD_ASSERT(a_wgt_range, clock, reset, rsp_valid |-> rsp_data.falloff_weight <= WGT_ONE, "weight above one")

   // Reset empties the outputs and holds off requests while the ROM fills.
   `GVD_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid && !req_ready, "busy after reset")

endmodule

bind gaussian_vertex_deform gvd_checker u_gvd_checker (.*);
